>>> rtl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// Homography point transform package
// Shared widths, register indexes, coefficient set and pipeline sideband types.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;   // default coordinate width
    localparam int COEF_W          = 32;   // every matrix entry is 32 bits
    localparam int FRAC_BITS       = 16;   // Q16.16 coordinates and offsets
    localparam int ONE_DEN_SHIFT   = 46;   // the constant 1 of the denominator
    localparam int QUOT_SHIFT      = 30;   // dividend pre-shift before the divide
    localparam int REG_IDX_W       = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_PERSP_X  = 3'd6,
        REG_PERSP_Y  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef_xx;
        logic [COEF_W-1:0] coef_xy;
        logic [COEF_W-1:0] offset_x;
        logic [COEF_W-1:0] coef_yx;
        logic [COEF_W-1:0] coef_yy;
        logic [COEF_W-1:0] offset_y;
        logic [COEF_W-1:0] persp_x;
        logic [COEF_W-1:0] persp_y;
    } coef_set_t;

    localparam coef_set_t COEF_RESET = '{
        coef_xx:  32'd65536,
        coef_xy:  32'd0,
        offset_x: 32'd0,
        coef_yx:  32'd0,
        coef_yy:  32'd65536,
        offset_y: 32'd0,
        persp_x:  32'd0,
        persp_y:  32'd0
    };

    // Sideband that travels with each request through the divider stages.
    typedef struct packed {
        logic valid;
        logic neg;     // quotient sign
        logic nneg;    // numerator sign, used for the zero-denominator bound
        logic dz;      // denominator is exactly zero
        logic ovf;     // quotient does not fit the divider's quotient bits
    } div_side_t;

    // Per-coordinate result flags handed from a divider to the top level.
    typedef struct packed {
        logic valid;
        logic dz;
        logic sat;
    } coord_flags_t;

endpackage

>>> rtl/homography_point_transform_core.sv
// ----------------------------------------------------------------------------
// Homography point transform core
// Maps a Q16.16 point through a 3x3 projective matrix with saturation.
// ----------------------------------------------------------------------------
// Each accepted request has its result on done, out_x, out_y and the flags
// once it has passed the front end and the divider, which resolves one
// quotient bit per stage. Throughput: one request every cycle. Reset clears
// all valid bits and loads the identity matrix; results cannot be held off
// by the receiver.
// ----------------------------------------------------------------------------
module homography_point_transform_core
    import hpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Request side.
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    // Result side.
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic                          divide_by_zero,
    output logic                          saturated,
    // Register write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [REG_IDX_W-1:0]          cfg_index,
    input  logic [COEF_W-1:0]             cfg_data
);

    localparam int SUM_W   = COORD_WIDTH + COEF_W + 1;
    localparam int LATENCY = COORD_WIDTH + 9;
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    coef_set_t               coef_reg;
    coef_set_t               coef_next;
    logic                    req_accept;
    logic                    sum_valid;
    logic signed [SUM_W-1:0] num_x;
    logic signed [SUM_W-1:0] num_y;
    logic signed [SUM_W-1:0] den;
    logic [COORD_WIDTH-1:0]  value_x;
    logic [COORD_WIDTH-1:0]  value_y;
    coord_flags_t            flags_x;
    coord_flags_t            flags_y;

    // The pipeline never stalls, so a request is taken in every cycle.
    assign busy       = 1'b0;
    assign req_accept = start && !busy;

    // Register writes are always accepted. The pipeline reads the matrix
    // directly; the user must rewrite it only while no request is in flight,
    // so every request sees a single consistent matrix; this is not enforced.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_COEF_XX:  coef_next.coef_xx  = cfg_data;
                REG_COEF_XY:  coef_next.coef_xy  = cfg_data;
                REG_OFFSET_X: coef_next.offset_x = cfg_data;
                REG_COEF_YX:  coef_next.coef_yx  = cfg_data;
                REG_COEF_YY:  coef_next.coef_yy  = cfg_data;
                REG_OFFSET_Y: coef_next.offset_y = cfg_data;
                REG_PERSP_X:  coef_next.persp_x  = cfg_data;
                REG_PERSP_Y:  coef_next.persp_y  = cfg_data;
                default:      coef_next          = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // Front end: four stages that form the two numerators (32 fraction bits)
    // and the denominator (46 fraction bits) exactly, with no rounding.
    hpt_dot #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_accept),
        .in_x      (in_x),
        .in_y      (in_y),
        .coef      (coef_reg),
        .sum_valid (sum_valid),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den)
    );

    // Back end: one divider per coordinate, both fed the same denominator,
    // so their valid bits and zero-denominator flags move in lockstep.
    hpt_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .num       (num_x),
        .den       (den),
        .res_value (value_x),
        .res_flags (flags_x)
    );

    hpt_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .num       (num_y),
        .den       (den),
        .res_value (value_y),
        .res_flags (flags_y)
    );

    // Both dividers end in registers, so all result ports but saturated
    // come straight from flops; saturated merges the two coordinates.
    assign done           = flags_x.valid;
    assign out_x          = value_x;
    assign out_y          = value_y;
    assign divide_by_zero = flags_x.dz;
    assign saturated      = flags_x.sat || flags_y.sat;

    // The two dividers must agree on which cycles carry a result and on
    // whether the shared denominator was zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (flags_x.valid == flags_y.valid) &&
        (!flags_x.valid || (flags_x.dz == flags_y.dz)))
    else $error("coordinate dividers out of step");

    // Every accepted request yields its result after the fixed latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |-> ##LATENCY done)
    else $error("result missing after pipeline latency");

    // No result appears without a request accepted a pipeline latency earlier.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req_accept, LATENCY))
    else $error("result without a matching request");

    // A clamped result with a valid denominator sits on a range bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated && !divide_by_zero) |->
        ((out_x == COORD_MIN) || (out_x == COORD_MAX) ||
         (out_y == COORD_MIN) || (out_y == COORD_MAX)))
    else $error("saturated result is not at a range bound");

endmodule

>>> rtl/hpt_dot.sv
// ----------------------------------------------------------------------------
// Homography point transform: projective dot products
// Forms both numerators and the denominator over four register stages.
// ----------------------------------------------------------------------------
module hpt_dot
    import hpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [COORD_WIDTH-1:0]          in_x,
    input  logic signed [COORD_WIDTH-1:0]          in_y,
    input  coef_set_t                              coef,
    output logic                                   sum_valid,
    output logic signed [COORD_WIDTH+COEF_W:0]     num_x,
    output logic signed [COORD_WIDTH+COEF_W:0]     num_y,
    output logic signed [COORD_WIDTH+COEF_W:0]     den
);

    localparam int LO_W   = COORD_WIDTH / 2;
    localparam int HI_W   = COORD_WIDTH - LO_W;
    localparam int PLO_W  = COEF_W + LO_W;
    localparam int PHI_W  = COEF_W + HI_W;
    localparam int PROD_W = COEF_W + COORD_WIDTH;
    localparam int SUM_W  = COORD_WIDTH + COEF_W + 1;
    localparam int NPROD  = 6;
    localparam logic signed [SUM_W-1:0] DEN_ONE = SUM_W'(1) <<< ONE_DEN_SHIFT;

    logic signed [COORD_WIDTH-1:0] x_reg;
    logic signed [COORD_WIDTH-1:0] y_reg;
    logic                          va_reg;
    logic                          vb_reg;
    logic                          vc_reg;
    logic                          vd_reg;

    logic signed [COEF_W-1:0]      coef_op [NPROD];
    logic signed [COORD_WIDTH-1:0] crd_op  [NPROD];
    logic signed [PLO_W-1:0]       plo_next [NPROD];
    logic signed [PHI_W-1:0]       phi_next [NPROD];
    logic signed [PLO_W-1:0]       plo_reg  [NPROD];
    logic signed [PHI_W-1:0]       phi_reg  [NPROD];
    logic signed [PROD_W-1:0]      prod_next [NPROD];
    logic signed [PROD_W-1:0]      prod_reg  [NPROD];

    logic signed [SUM_W-1:0]       num_x_next;
    logic signed [SUM_W-1:0]       num_y_next;
    logic signed [SUM_W-1:0]       den_next;
    logic signed [SUM_W-1:0]       num_x_reg;
    logic signed [SUM_W-1:0]       num_y_reg;
    logic signed [SUM_W-1:0]       den_reg;

    // Product k pairs a matrix entry with the coordinate it weights.
    always_comb
    begin
        coef_op[0] = $signed(coef.coef_xx);
        crd_op[0]  = x_reg;
        coef_op[1] = $signed(coef.coef_xy);
        crd_op[1]  = y_reg;
        coef_op[2] = $signed(coef.coef_yx);
        crd_op[2]  = x_reg;
        coef_op[3] = $signed(coef.coef_yy);
        crd_op[3]  = y_reg;
        coef_op[4] = $signed(coef.persp_x);
        crd_op[4]  = x_reg;
        coef_op[5] = $signed(coef.persp_y);
        crd_op[5]  = y_reg;
    end

    // Each product is split on the coordinate into an unsigned low half and
    // a signed high half so no single multiplier exceeds 32 bits a side.
    always_comb
    begin
        for (int k = 0; k < NPROD; k++)
        begin
            plo_next[k] = coef_op[k] * $signed({1'b0, crd_op[k][LO_W-1:0]});
            phi_next[k] = coef_op[k] * $signed(crd_op[k][COORD_WIDTH-1:LO_W]);
            prod_next[k] = (PROD_W'(phi_reg[k]) <<< LO_W) + PROD_W'(plo_reg[k]);
        end
    end

    always_comb
    begin
        num_x_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                   + (SUM_W'($signed(coef.offset_x)) <<< FRAC_BITS);
        num_y_next = SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3])
                   + (SUM_W'($signed(coef.offset_y)) <<< FRAC_BITS);
        den_next   = SUM_W'(prod_reg[4]) + SUM_W'(prod_reg[5]) + DEN_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= in_x;
        y_reg <= in_y;
        for (int k = 0; k < NPROD; k++)
        begin
            plo_reg[k]  <= plo_next[k];
            phi_reg[k]  <= phi_next[k];
            prod_reg[k] <= prod_next[k];
        end
        num_x_reg <= num_x_next;
        num_y_reg <= num_y_next;
        den_reg   <= den_next;
    end

    assign sum_valid = vd_reg;
    assign num_x     = num_x_reg;
    assign num_y     = num_y_reg;
    assign den       = den_reg;

endmodule

>>> rtl/hpt_div.sv
// ----------------------------------------------------------------------------
// Homography point transform: pipelined divider
// Restoring division, one quotient bit per stage, with rounding and clamping.
// ----------------------------------------------------------------------------
module hpt_div
    import hpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [COORD_WIDTH+COEF_W:0]     num,
    input  logic signed [COORD_WIDTH+COEF_W:0]     den,
    output logic [COORD_WIDTH-1:0]                 res_value,
    output coord_flags_t                           res_flags
);

    localparam int SUM_W = COORD_WIDTH + COEF_W + 1;
    localparam int MAG_W = COORD_WIDTH + COEF_W;
    localparam int QK    = COORD_WIDTH + 1;
    localparam int CMP_W = MAG_W + QUOT_SHIFT;

    localparam logic [QK:0] LIM_NEG = {2'b00, 1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [QK:0] LIM_POS = LIM_NEG - 1'b1;
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    // Stage A: magnitudes and signs.
    logic             num_neg;
    logic             den_neg;
    logic [MAG_W-1:0] nmag_next;
    logic [MAG_W-1:0] dmag_next;
    div_side_t        a_side_next;
    logic [MAG_W-1:0] nmag_reg;
    logic [MAG_W-1:0] dmag_reg;
    div_side_t        a_side_reg;

    // Stage B: overflow test and the starting remainder.
    logic [CMP_W-1:0] n_full;
    logic [CMP_W-1:0] top_ext;
    logic [CMP_W-1:0] d_ext;
    div_side_t        b_side_next;

    // Quotient stages; index 0 holds stage B, index k+1 follows step k.
    logic [MAG_W-1:0] rem_reg  [QK+1];
    logic [MAG_W-1:0] dvs_reg  [QK+1];
    logic [QK-1:0]    bits_reg [QK+1];
    logic [QK-1:0]    quo_reg  [QK+1];
    div_side_t        side_reg [QK+1];
    logic [MAG_W-1:0] rem_next  [QK];
    logic [QK-1:0]    bits_next [QK];
    logic [QK-1:0]    quo_next  [QK];

    // Rounding stage.
    logic [MAG_W:0]   rnd_trial;
    logic             rnd_up;
    logic [QK:0]      qr_next;
    logic [QK:0]      qr_reg;
    div_side_t        r_side_reg;

    // Clamping stage.
    logic                   over;
    logic [COORD_WIDTH-1:0] value_next;
    coord_flags_t           flags_next;
    logic [COORD_WIDTH-1:0] value_reg;
    coord_flags_t           flags_reg;

    always_comb
    begin
        num_neg   = num[SUM_W-1];
        den_neg   = den[SUM_W-1];
        nmag_next = num_neg ? MAG_W'(-num) : MAG_W'(num);
        dmag_next = den_neg ? MAG_W'(-den) : MAG_W'(den);
        a_side_next.valid = in_valid;
        a_side_next.neg   = num_neg ^ den_neg;
        a_side_next.nneg  = num_neg;
        a_side_next.dz    = (den == '0);
        a_side_next.ovf   = 1'b0;
    end

    always_comb
    begin
        n_full  = {nmag_reg, {QUOT_SHIFT{1'b0}}};
        top_ext = n_full >> QK;
        d_ext   = CMP_W'(dmag_reg);
        b_side_next     = a_side_reg;
        b_side_next.ovf = (top_ext >= d_ext);
    end

    always_comb
    begin
        logic [MAG_W:0] trial;
        logic [MAG_W:0] dvs_ext;
        logic           take;
        for (int k = 0; k < QK; k++)
        begin
            trial   = {rem_reg[k], bits_reg[k][QK-1]};
            dvs_ext = {1'b0, dvs_reg[k]};
            take    = (trial >= dvs_ext);
            rem_next[k]  = take ? MAG_W'(trial - dvs_ext) : trial[MAG_W-1:0];
            bits_next[k] = bits_reg[k] << 1;
            quo_next[k]  = {quo_reg[k][QK-2:0], take};
        end
    end

    // Round half away from zero on the magnitude: bump when 2r >= d.
    always_comb
    begin
        rnd_trial = {rem_reg[QK], 1'b0};
        rnd_up    = (rnd_trial >= {1'b0, dvs_reg[QK]});
        qr_next   = (QK+1)'(quo_reg[QK]) + (QK+1)'(rnd_up);
    end

    always_comb
    begin
        over = r_side_reg.ovf || (qr_reg > (r_side_reg.neg ? LIM_NEG : LIM_POS));
        flags_next.valid = r_side_reg.valid;
        flags_next.dz    = r_side_reg.dz;
        if (r_side_reg.dz)
        begin
            value_next     = r_side_reg.nneg ? COORD_MIN : COORD_MAX;
            flags_next.sat = 1'b1;
        end
        else if (over)
        begin
            value_next     = r_side_reg.neg ? COORD_MIN : COORD_MAX;
            flags_next.sat = 1'b1;
        end
        else
        begin
            value_next     = r_side_reg.neg ? -qr_reg[COORD_WIDTH-1:0]
                                            : qr_reg[COORD_WIDTH-1:0];
            flags_next.sat = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_side_reg <= '0;
            for (int k = 0; k <= QK; k++)
            begin
                side_reg[k] <= '0;
            end
            r_side_reg <= '0;
            flags_reg  <= '0;
        end
        else
        begin
            a_side_reg  <= a_side_next;
            side_reg[0] <= b_side_next;
            for (int k = 0; k < QK; k++)
            begin
                side_reg[k+1] <= side_reg[k];
            end
            r_side_reg <= side_reg[QK];
            flags_reg  <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nmag_reg    <= nmag_next;
        dmag_reg    <= dmag_next;
        rem_reg[0]  <= top_ext[MAG_W-1:0];
        dvs_reg[0]  <= dmag_reg;
        bits_reg[0] <= n_full[QK-1:0];
        quo_reg[0]  <= '0;
        for (int k = 0; k < QK; k++)
        begin
            rem_reg[k+1]  <= rem_next[k];
            dvs_reg[k+1]  <= dvs_reg[k];
            bits_reg[k+1] <= bits_next[k];
            quo_reg[k+1]  <= quo_next[k];
        end
        qr_reg    <= qr_next;
        value_reg <= value_next;
    end

    assign res_value = value_reg;
    assign res_flags = flags_reg;

endmodule
